// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the Morse text encoder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("concurrent assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: sv/mte_pkg.sv
// ---------------------------------------------------------------------------
// mte_pkg
// Shared types, symbol codes and the Morse lookup table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

  localparam int SYM_W  = 2;
  localparam int CODE_W = 6;   // longest code in the table
  localparam int LEN_W  = 3;   // holds 0..CODE_W

  localparam logic [SYM_W-1:0] SYM_DOT   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_DASH  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_SPACE = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // pattern is left aligned: bit CODE_W-1 is the first symbol, 1 = dash
  typedef struct packed {
    logic              found;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] pattern;
  } code_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic code_t lookup_code(input logic [7:0] ch_in);
    logic [7:0] ch;
    code_t      c;
    ch = ch_in;
    if (ch >= "A" && ch <= "Z") begin
      ch = ch + 8'h20;
    end
    c.found = 1'b1;
    unique case (ch)
      "a": begin c.len = 3'd2; c.pattern = 6'b010000; end
      "b": begin c.len = 3'd4; c.pattern = 6'b100000; end
      "c": begin c.len = 3'd4; c.pattern = 6'b101000; end
      "d": begin c.len = 3'd3; c.pattern = 6'b100000; end
      "e": begin c.len = 3'd1; c.pattern = 6'b000000; end
      "f": begin c.len = 3'd4; c.pattern = 6'b001000; end
      "g": begin c.len = 3'd3; c.pattern = 6'b110000; end
      "h": begin c.len = 3'd4; c.pattern = 6'b000000; end
      "i": begin c.len = 3'd2; c.pattern = 6'b000000; end
      "j": begin c.len = 3'd4; c.pattern = 6'b011100; end
      "k": begin c.len = 3'd3; c.pattern = 6'b101000; end
      "l": begin c.len = 3'd4; c.pattern = 6'b010000; end
      "m": begin c.len = 3'd2; c.pattern = 6'b110000; end
      "n": begin c.len = 3'd2; c.pattern = 6'b100000; end
      "o": begin c.len = 3'd3; c.pattern = 6'b111000; end
      "p": begin c.len = 3'd4; c.pattern = 6'b011000; end
      "q": begin c.len = 3'd4; c.pattern = 6'b110100; end
      "r": begin c.len = 3'd3; c.pattern = 6'b010000; end
      "s": begin c.len = 3'd3; c.pattern = 6'b000000; end
      "t": begin c.len = 3'd1; c.pattern = 6'b100000; end
      "u": begin c.len = 3'd3; c.pattern = 6'b001000; end
      "v": begin c.len = 3'd4; c.pattern = 6'b000100; end
      "w": begin c.len = 3'd3; c.pattern = 6'b011000; end
      "x": begin c.len = 3'd4; c.pattern = 6'b100100; end
      "y": begin c.len = 3'd4; c.pattern = 6'b101100; end
      "z": begin c.len = 3'd4; c.pattern = 6'b110000; end
      "0": begin c.len = 3'd5; c.pattern = 6'b111110; end
      "1": begin c.len = 3'd5; c.pattern = 6'b011110; end
      "2": begin c.len = 3'd5; c.pattern = 6'b001110; end
      "3": begin c.len = 3'd5; c.pattern = 6'b000110; end
      "4": begin c.len = 3'd5; c.pattern = 6'b000010; end
      "5": begin c.len = 3'd5; c.pattern = 6'b000000; end
      "6": begin c.len = 3'd5; c.pattern = 6'b100000; end
      "7": begin c.len = 3'd5; c.pattern = 6'b110000; end
      "8": begin c.len = 3'd5; c.pattern = 6'b111000; end
      "9": begin c.len = 3'd5; c.pattern = 6'b111100; end
      ".": begin c.len = 3'd6; c.pattern = 6'b010101; end
      ",": begin c.len = 3'd6; c.pattern = 6'b110011; end
      "?": begin c.len = 3'd6; c.pattern = 6'b001100; end
      "/": begin c.len = 3'd5; c.pattern = 6'b100100; end
      "@": begin c.len = 3'd6; c.pattern = 6'b011010; end
      default: begin
        c.found   = 1'b0;
        c.len     = '0;
        c.pattern = '0;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/morse_text_encoder.sv
// A character's first symbol is offered once its job is registered at the queue head.
// Throughput: one symbol per cycle while out_tready is high; a character holds the
//   serializer for its code and one or two spaces, 1 to MAX_CODE_LENGTH + 2 symbols.
// Input bytes are taken every cycle while the four-entry job queue has room.
// Reset: synchronous, active low; clears word state, queue pointers and symbol position.
// ---------------------------------------------------------------------------
// morse_text_encoder
// Streams text bytes in and Morse symbols (dot, dash, space) out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morse_text_encoder #(
  parameter int MAX_CODE_LENGTH = 6
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,    // [7:0] text_byte
  input  wire        in_tlast,    // end_of_text
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,   // [1:0] symbol, [7:2] zero
  output logic       out_tlast    // last_of_run
);

  localparam int JLEN_W = $clog2(MAX_CODE_LENGTH + 1);
  localparam int JOB_W  = MAX_CODE_LENGTH + JLEN_W + 2;

  mte_pkg::q_stat_t           q_stat;
  logic                       push;
  logic                       pop;
  logic [MAX_CODE_LENGTH-1:0] f_bits;
  logic [JLEN_W-1:0]          f_len;
  logic [1:0]                 f_tail;
  logic [JOB_W-1:0]           wr_job;
  logic [JOB_W-1:0]           rd_job;
  logic [mte_pkg::SYM_W-1:0]  sym;

  mte_front #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .JLEN_W         (JLEN_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .job_bits (f_bits),
    .job_len  (f_len),
    .job_tail (f_tail)
  );

  assign wr_job = {f_bits, f_len, f_tail};

  mte_queue #(
    .DATA_W(JOB_W)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(wr_job),
    .pop    (pop),
    .rd_data(rd_job),
    .q_stat (q_stat)
  );

  mte_back #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
    .JLEN_W         (JLEN_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .job_bits  (rd_job[JOB_W-1 -: MAX_CODE_LENGTH]),
    .job_len   (rd_job[JLEN_W+1:2]),
    .job_tail  (rd_job[1:0]),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sym       (sym),
    .out_tlast (out_tlast)
  );

  assign out_tdata = {(8 - mte_pkg::SYM_W)'(0), sym};

endmodule

`default_nettype wire

// File: sv/mte_front.sv
// ---------------------------------------------------------------------------
// mte_front
// Accepts text bytes, tracks word state and turns each byte that sends symbols into
// a job: code pattern, code length and number of trailing spaces.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mte_front #(
  parameter int MAX_CODE_LENGTH = 6,
  parameter int JLEN_W          = 3
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [7:0]                 in_tdata,   // [7:0] text_byte
  input  wire                        in_tlast,   // end_of_text
  input  mte_pkg::q_stat_t           q_stat,
  output logic                       push,
  output logic [MAX_CODE_LENGTH-1:0] job_bits,
  output logic [JLEN_W-1:0]          job_len,
  output logic [1:0]                 job_tail
);

  logic          inside_r, inside_nxt;
  logic          sent_r, sent_nxt;
  mte_pkg::code_t code;
  logic          accept;
  logic          is_space;
  logic          code_ok;
  logic          ins_after;
  logic          sent_after;
  logic          word_sp_space;
  logic          word_sp_end;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign code      = mte_pkg::lookup_code(in_tdata);
  assign is_space  = (in_tdata == mte_pkg::CHAR_SPACE);
  // codes longer than the serializer can hold count as unknown
  assign code_ok   = !is_space && code.found && (int'(code.len) <= MAX_CODE_LENGTH);

  always_comb begin
    if (is_space) begin
      word_sp_space = inside_r && sent_r;
      ins_after     = 1'b0;
      sent_after    = sent_r;
    end else begin
      word_sp_space = 1'b0;
      ins_after     = 1'b1;
      sent_after    = sent_r || code_ok;
    end
    word_sp_end = in_tlast && ins_after && sent_after;
    inside_nxt  = inside_r;
    sent_nxt    = sent_r;
    if (accept) begin
      inside_nxt = in_tlast ? 1'b0 : ins_after;
      sent_nxt   = in_tlast ? 1'b0 : sent_after;
    end
  end

  // at most two of the three spaces can be set for one byte
  assign job_tail = 2'(code_ok) + 2'(word_sp_space) + 2'(word_sp_end);
  assign job_len  = code_ok ? JLEN_W'(code.len) : '0;
  // drop bytes that send nothing
  assign push     = accept && (job_tail != 2'd0);

  for (genvar g = 0; g < MAX_CODE_LENGTH; g++) begin : g_bits
    if (g < mte_pkg::CODE_W) begin : g_tab
      assign job_bits[MAX_CODE_LENGTH-1-g] = code.pattern[mte_pkg::CODE_W-1-g];
    end else begin : g_pad
      assign job_bits[MAX_CODE_LENGTH-1-g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      sent_r   <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      sent_r   <= sent_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mte_queue.sv
// ---------------------------------------------------------------------------
// mte_queue
// Four-entry job queue between classifier and serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mte_queue #(
  parameter int DATA_W = 12
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire  [DATA_W-1:0]  wr_data,
  input  wire                pop,
  output logic [DATA_W-1:0]  rd_data,
  output mte_pkg::q_stat_t   q_stat
);

  logic [DATA_W-1:0]         mem_r [mte_pkg::QUEUE_DEPTH];
  logic [mte_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mte_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mte_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign q_stat.full  = (count_r == mte_pkg::QCNT_W'(mte_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + mte_pkg::QCNT_W'(do_push) - mte_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk, rst_n, push && q_stat.full)
  `ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && q_stat.empty)
  `ASSERT_CLK(a_q_ptr_gap, clk, rst_n,
              (count_r != '0 && count_r != mte_pkg::QCNT_W'(mte_pkg::QUEUE_DEPTH)) |-> (wr_ptr_r != rd_ptr_r))

endmodule

`default_nettype wire

// File: sv/mte_back.sv
// ---------------------------------------------------------------------------
// mte_back
// Serializes the head job of the queue into one symbol per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mte_back #(
  parameter int MAX_CODE_LENGTH = 6,
  parameter int JLEN_W          = 3
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  mte_pkg::q_stat_t           q_stat,
  input  wire  [MAX_CODE_LENGTH-1:0] job_bits,
  input  wire  [JLEN_W-1:0]          job_len,
  input  wire  [1:0]                 job_tail,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [mte_pkg::SYM_W-1:0]  sym,
  output logic                       out_tlast
);

  localparam int POS_W = $clog2(MAX_CODE_LENGTH + 3);
  localparam int IDX_W = $clog2(MAX_CODE_LENGTH);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] rev;
  logic [IDX_W-1:0] idx;
  logic             in_code;
  logic             fire;

  assign out_tvalid = !q_stat.empty;
  assign total      = POS_W'(job_len) + POS_W'(job_tail);
  assign out_tlast  = (pos_r == total - POS_W'(1));
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && out_tlast;
  assign in_code    = (pos_r < POS_W'(job_len));
  // code symbols run from the top bit down
  assign rev        = POS_W'(MAX_CODE_LENGTH - 1) - pos_r;
  assign idx        = rev[IDX_W-1:0];

  always_comb begin
    if (!in_code) begin
      sym = mte_pkg::SYM_SPACE;
    end else if (job_bits[idx]) begin
      sym = mte_pkg::SYM_DASH;
    end else begin
      sym = mte_pkg::SYM_DOT;
    end
    pos_nxt = pos_r;
    if (fire) begin
      pos_nxt = out_tlast ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  `ASSERT_CLK(a_pos_in_range, clk, rst_n, out_tvalid |-> (pos_r < total))
  `ASSERT_CLK(a_pos_idle, clk, rst_n, !out_tvalid |-> (pos_r == '0))
  `ASSERT_CLK(a_job_nonempty, clk, rst_n, out_tvalid |-> (job_tail != 2'd0))

endmodule

`default_nettype wire

// File: bench/tb_morse_text_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_morse_text_encoder
// Drives text bytes into the encoder and checks every Morse symbol against an
// in-bench encoder: directed runs for case folding, the table extremes,
// unknown bytes and word breaks, then random messages with random idling on
// both streams.
// ---------------------------------------------------------------------------

module tb_morse_text_encoder;

  localparam int MAX_CODE_LENGTH = 6;
  localparam int RANDOM_ITEMS    = 130;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int TAIL_CYCLES     = 20;

  typedef struct {
    logic [mte_pkg::SYM_W-1:0] sym;
    logic                      last;
  } symbol_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  symbol_t pending_symbols[$];
  logic    word_open;
  logic    sent_in_msg;
  logic    sender_idles;
  logic    receiver_idles;
  int      error_count;
  int      cycle_count;

  logic [7:0] punct_chars [5] = '{".", ",", "?", "/", "@"};

  morse_text_encoder #(
    .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // dots and dashes for one character, empty if it has no code
  function automatic string morse_pattern(input logic [7:0] ch_in);
    logic [7:0] ch;
    ch = ch_in;
    if (ch >= "A" && ch <= "Z") begin
      ch = ch + 8'h20;
    end
    case (ch)
      "a": return ".-";     "b": return "-...";   "c": return "-.-.";
      "d": return "-..";    "e": return ".";      "f": return "..-.";
      "g": return "--.";    "h": return "....";   "i": return "..";
      "j": return ".---";   "k": return "-.-";    "l": return ".-..";
      "m": return "--";     "n": return "-.";     "o": return "---";
      "p": return ".--.";   "q": return "--.-";   "r": return ".-.";
      "s": return "...";    "t": return "-";      "u": return "..-";
      "v": return "...-";   "w": return ".--";    "x": return "-..-";
      "y": return "-.--";   "z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-"; ",": return "--..--"; "?": return "..--..";
      "/": return "-..-.";  "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic void push_symbol(input logic [mte_pkg::SYM_W-1:0] sym);
    symbol_t s;
    s.sym  = sym;
    s.last = 1'b0;
    pending_symbols.push_back(s);
  endfunction

  // queue the symbols one accepted byte must produce
  function automatic void encode_char(input logic [7:0] ch, input logic eot);
    string code;
    int    base;
    base = pending_symbols.size();
    if (ch == mte_pkg::CHAR_SPACE) begin
      if (word_open && sent_in_msg) push_symbol(mte_pkg::SYM_SPACE);
      word_open = 1'b0;
    end else begin
      code      = morse_pattern(ch);
      word_open = 1'b1;
      if (code.len() > 0 && code.len() <= MAX_CODE_LENGTH) begin
        for (int i = 0; i < code.len(); i++) begin
          push_symbol(code[i] == "-" ? mte_pkg::SYM_DASH : mte_pkg::SYM_DOT);
        end
        push_symbol(mte_pkg::SYM_SPACE);
        sent_in_msg = 1'b1;
      end
    end
    if (eot) begin
      if (word_open && sent_in_msg) push_symbol(mte_pkg::SYM_SPACE);
      word_open   = 1'b0;
      sent_in_msg = 1'b0;
    end
    if (pending_symbols.size() > base) begin
      pending_symbols[pending_symbols.size()-1].last = 1'b1;
    end
  endfunction

  function automatic int draw_gap(input logic idles);
    if (!idles) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic eot);
    int gap;
    gap = draw_gap(sender_idles);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    encode_char(ch, eot);
  endtask

  task automatic send_text(input string s, input logic eot_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_at_end && (i == s.len() - 1));
    end
  endtask

  // drop valid and hold until every queued symbol has come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  task automatic test_table_and_folding();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    send_text("Az09.,?/@Z", 1'b1);
    wait_drained();
  endtask

  task automatic test_unknown_bytes();
    // unknown byte opens a word; the space after it has nothing to close
    send_byte(8'h00, 1'b0);
    send_byte(mte_pkg::CHAR_SPACE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte("e", 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_drained();
  endtask

  task automatic test_word_breaks();
    // repeated spaces, then a space as the final byte of the message
    sender_idles = 1'b0;
    send_text("t   k ", 1'b1);
    send_byte("~", 1'b1);
    wait_drained();
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'("a" + $urandom_range(0, 25));
    if (r < 45) return 8'("A" + $urandom_range(0, 25));
    if (r < 55) return 8'("0" + $urandom_range(0, 9));
    if (r < 63) return punct_chars[$urandom_range(0, 4)];
    if (r < 82) return mte_pkg::CHAR_SPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_messages();
    int sent;
    int msg_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // switch idling per message so some stretches run at full rate
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      msg_len        = $urandom_range(1, 12);
      for (int i = 0; i < msg_len; i++) begin
        send_byte(pick_text_byte(), i == msg_len - 1);
      end
      sent += msg_len;
    end
    wait_drained();
  endtask

  // result side: random stall before each symbol while receiver_idles is set
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(receiver_idles);
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : check_symbols
    symbol_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got tdata %h tlast %b",
                 $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_tdata !== {6'd0, want.sym}) begin
          $display("%0t: symbol mismatch, expected %h, got %h",
                   $time, {6'd0, want.sym}, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: tlast mismatch, expected %b, got %b",
                   $time, want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 8'h00;
    in_tlast       = 1'b0;
    word_open      = 1'b0;
    sent_in_msg    = 1'b0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    error_count    = 0;
    cycle_count    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_table_and_folding();
    test_unknown_bytes();
    test_word_breaks();
    test_random_messages();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/mte_pkg.sv
sv/mte_front.sv
sv/mte_queue.sv
sv/mte_back.sv
sv/morse_text_encoder.sv
bench/tb_morse_text_encoder.sv
